### rtl/hars_pkg.sv
// Shared types and constants for the HCI advertising report splitter.
// No dependencies; used by every module in rtl/.
package hars_pkg;

  localparam logic [7:0] H4_EVENT    = 8'h04;
  localparam logic [7:0] EVT_LE_META = 8'h3E;
  localparam logic [7:0] EVT_VENDOR  = 8'hFF;
  localparam logic [7:0] SUB_ADV_RPT = 8'h02;
  localparam logic [7:0] ONE_REPORT  = 8'h01;
  localparam logic [7:0] FRAME_EXTRA = 8'd12;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned HELD_BYTES = HDR_BYTES - 1;
  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned BURST_LEN = FRAME_BYTES + HDR_BYTES;

  localparam logic [3:0] HDR_LAST_IDX = 4'(HDR_BYTES - 1);
  localparam logic [3:0] BURST_LAST_IDX = 4'(BURST_LEN - 1);

  localparam logic [3:0] BEAT_CODE = 4'd0;
  localparam logic [3:0] BEAT_LEN  = 4'd1;
  localparam logic [3:0] BEAT_SUB  = 4'd2;
  localparam logic [3:0] BEAT_NUM  = 4'd3;

  localparam logic SRC_ADV    = 1'b0;
  localparam logic SRC_VENDOR = 1'b1;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_CODE  = 10'b00_0000_0010,
    PH_VLEN  = 10'b00_0000_0100,
    PH_VPASS = 10'b00_0000_1000,
    PH_MLEN  = 10'b00_0001_0000,
    PH_SUB   = 10'b00_0010_0000,
    PH_NUM   = 10'b00_0100_0000,
    PH_HDR   = 10'b00_1000_0000,
    PH_DATA  = 10'b01_0000_0000,
    PH_RSSI  = 10'b10_0000_0000
  } phase_t;

  // One pending output job: a single byte, or a 13-byte re-framed header burst.
  typedef struct packed {
    logic                         burst;
    logic [7:0]                   data;
    logic                         last;
    logic                         src;
    logic [31:0]                  count;
    logic [HDR_BYTES-1:0][7:0]    hdr;
  } desc_t;

endpackage

### rtl/hars_parser.sv
// Event parser: H4 byte state machine, header hold and report counter.
// Produces at most one output job per input byte into a one-entry job register.
// Depends on hars_pkg.
module hars_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_first,
  input  logic            take,
  output logic            desc_valid,
  output hars_pkg::desc_t desc
);

  hars_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  reports_left_r, reports_left_nxt;
  logic [3:0]  field_index_r, field_index_nxt;
  logic [7:0]  payload_left_r, payload_left_nxt;
  logic [31:0] reports_emitted_r, reports_emitted_nxt;
  logic [hars_pkg::HELD_BYTES-1:0][7:0] hold_r;
  logic        hold_we;

  logic            desc_v_r;
  hars_pkg::desc_t desc_r, job;
  logic            emit;
  logic            accept;
  logic [7:0]      bl_dec, pl_dec, rl_dec;
  logic            fits;

  assign in_ready   = !desc_v_r || take;
  assign accept     = in_valid && in_ready;
  assign desc_valid = desc_v_r;
  assign desc       = desc_r;

  assign bl_dec = bytes_left_r - 8'd1;
  assign pl_dec = payload_left_r - 8'd1;
  assign rl_dec = reports_left_r - 8'd1;
  assign fits   = {1'b0, bl_dec} >= ({1'b0, in_byte} + 9'd1);

  always_comb begin
    phase_nxt           = phase_r;
    bytes_left_nxt      = bytes_left_r;
    reports_left_nxt    = reports_left_r;
    field_index_nxt     = field_index_r;
    payload_left_nxt    = payload_left_r;
    reports_emitted_nxt = reports_emitted_r;
    hold_we             = 1'b0;
    emit                = 1'b0;
    job.burst           = 1'b0;
    job.data            = in_byte;
    job.last            = 1'b0;
    job.src             = hars_pkg::SRC_ADV;
    job.count           = reports_emitted_r;
    job.hdr             = {in_byte, hold_r};
    if (accept) begin
      if (in_first) begin
        phase_nxt = (in_byte == hars_pkg::H4_EVENT) ? hars_pkg::PH_CODE : hars_pkg::PH_IDLE;
      end else begin
        case (phase_r)
          hars_pkg::PH_IDLE: begin
            phase_nxt = hars_pkg::PH_IDLE;
          end
          hars_pkg::PH_CODE: begin
            if (in_byte == hars_pkg::EVT_VENDOR) begin
              emit      = 1'b1;
              job.src   = hars_pkg::SRC_VENDOR;
              phase_nxt = hars_pkg::PH_VLEN;
            end else if (in_byte == hars_pkg::EVT_LE_META) begin
              phase_nxt = hars_pkg::PH_MLEN;
            end else begin
              phase_nxt = hars_pkg::PH_IDLE;
            end
          end
          hars_pkg::PH_VLEN: begin
            emit           = 1'b1;
            job.src        = hars_pkg::SRC_VENDOR;
            job.last       = (in_byte == 8'd0);
            bytes_left_nxt = in_byte;
            phase_nxt      = (in_byte == 8'd0) ? hars_pkg::PH_IDLE : hars_pkg::PH_VPASS;
          end
          hars_pkg::PH_VPASS: begin
            emit           = 1'b1;
            job.src        = hars_pkg::SRC_VENDOR;
            job.last       = (bl_dec == 8'd0);
            bytes_left_nxt = bl_dec;
            if (bl_dec == 8'd0) phase_nxt = hars_pkg::PH_IDLE;
          end
          hars_pkg::PH_MLEN: begin
            bytes_left_nxt = in_byte;
            phase_nxt      = (in_byte == 8'd0) ? hars_pkg::PH_IDLE : hars_pkg::PH_SUB;
          end
          hars_pkg::PH_SUB: begin
            bytes_left_nxt = bl_dec;
            phase_nxt = (in_byte == hars_pkg::SUB_ADV_RPT && bl_dec != 8'd0) ?
                        hars_pkg::PH_NUM : hars_pkg::PH_IDLE;
          end
          hars_pkg::PH_NUM: begin
            bytes_left_nxt   = bl_dec;
            reports_left_nxt = in_byte;
            field_index_nxt  = 4'd0;
            phase_nxt = (in_byte != 8'd0 && bl_dec != 8'd0) ?
                        hars_pkg::PH_HDR : hars_pkg::PH_IDLE;
          end
          hars_pkg::PH_HDR: begin
            hold_we         = (field_index_r < hars_pkg::HDR_LAST_IDX);
            field_index_nxt = field_index_r + 4'd1;
            bytes_left_nxt  = bl_dec;
            if (field_index_r >= hars_pkg::HDR_LAST_IDX) begin
              if (fits) begin
                emit             = 1'b1;
                job.burst        = 1'b1;
                job.data         = hars_pkg::FRAME_EXTRA + in_byte;
                payload_left_nxt = in_byte;
                phase_nxt = (in_byte == 8'd0) ? hars_pkg::PH_RSSI : hars_pkg::PH_DATA;
              end else begin
                phase_nxt = hars_pkg::PH_IDLE;
              end
            end else if (bl_dec == 8'd0) begin
              phase_nxt = hars_pkg::PH_IDLE;
            end
          end
          hars_pkg::PH_DATA: begin
            emit             = 1'b1;
            bytes_left_nxt   = bl_dec;
            payload_left_nxt = pl_dec;
            if (pl_dec == 8'd0) phase_nxt = hars_pkg::PH_RSSI;
          end
          hars_pkg::PH_RSSI: begin
            emit                = 1'b1;
            job.last            = 1'b1;
            bytes_left_nxt      = bl_dec;
            reports_emitted_nxt = reports_emitted_r + 32'd1;
            reports_left_nxt    = rl_dec;
            field_index_nxt     = 4'd0;
            phase_nxt = (rl_dec != 8'd0 && bl_dec != 8'd0) ?
                        hars_pkg::PH_HDR : hars_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt = hars_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= hars_pkg::PH_IDLE;
      bytes_left_r      <= 8'd0;
      reports_left_r    <= 8'd0;
      field_index_r     <= 4'd0;
      payload_left_r    <= 8'd0;
      reports_emitted_r <= 32'd0;
      desc_v_r          <= 1'b0;
    end else begin
      phase_r           <= phase_nxt;
      bytes_left_r      <= bytes_left_nxt;
      reports_left_r    <= reports_left_nxt;
      field_index_r     <= field_index_nxt;
      payload_left_r    <= payload_left_nxt;
      reports_emitted_r <= reports_emitted_nxt;
      if (accept && emit) begin
        desc_v_r <= 1'b1;
      end else if (take) begin
        desc_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) desc_r <= job;
    if (hold_we) hold_r[field_index_r[2:0]] <= in_byte;
  end

  a_first_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_first && !take) |=> (desc_v_r == $past(desc_v_r)))
    else $error("packet start byte produced an output job");

endmodule

### rtl/hars_out.sv
// Output sequencer: result register that plays out single bytes or
// the 13-byte re-framed report header. Depends on hars_pkg.
module hars_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            desc_valid,
  input  hars_pkg::desc_t desc,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_source,
  output logic [31:0]     report_count
);

  logic            out_v_r;
  logic [3:0]      idx_r;
  hars_pkg::desc_t job_r;
  logic            final_beat;
  logic [3:0]      hdr_idx;

  assign final_beat = !job_r.burst || (idx_r == hars_pkg::BURST_LAST_IDX);
  assign take       = desc_valid && (!out_v_r || (out_ready && final_beat));
  assign hdr_idx    = idx_r - 4'(hars_pkg::FRAME_BYTES);

  always_comb begin
    out_byte = job_r.data;
    if (job_r.burst) begin
      case (idx_r)
        hars_pkg::BEAT_CODE: out_byte = hars_pkg::EVT_LE_META;
        hars_pkg::BEAT_LEN:  out_byte = job_r.data;
        hars_pkg::BEAT_SUB:  out_byte = hars_pkg::SUB_ADV_RPT;
        hars_pkg::BEAT_NUM:  out_byte = hars_pkg::ONE_REPORT;
        default:             out_byte = job_r.hdr[hdr_idx];
      endcase
    end
  end

  assign out_valid    = out_v_r;
  assign out_last     = !job_r.burst && job_r.last;
  assign out_source   = job_r.src;
  assign report_count = job_r.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      idx_r   <= 4'd0;
    end else if (take) begin
      out_v_r <= 1'b1;
      idx_r   <= 4'd0;
    end else if (out_v_r && out_ready) begin
      if (final_beat) begin
        out_v_r <= 1'b0;
        idx_r   <= 4'd0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) job_r <= desc;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= hars_pkg::BURST_LAST_IDX)
    else $error("burst beat index out of range");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> (idx_r == 4'd0))
    else $error("beat index not cleared while empty");

  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && job_r.burst && idx_r != 4'd0) |-> (report_count == $past(report_count)))
    else $error("report count changed inside a header burst");

endmodule

### rtl/hci_adv_report_splitter_core.sv
// Top level of the HCI advertising report splitter.
// Instantiates hars_parser and hars_out; depends on hars_pkg.
//
//  channel | direction | ports                                        | item
//  in      | input     | in_valid in_ready in_byte in_first           | one H4 byte
//  out     | output    | out_valid out_ready out_byte out_last        | one event byte
//          |           | out_source out_report_count                  |
//
// One input byte per cycle while the job register has room or hands off.
// An emitted byte goes through the job register, then the result register.
// A completed report header plays out 13 bytes, one per cycle while out_ready is high,
// from the result register; the one-entry job register takes one more item meanwhile.
// Synchronous active-low reset returns the parser to idle, count to zero.
// out_ready low holds the result; input stalls only once the job register is full.
module hci_adv_report_splitter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_source,
  output logic [31:0] out_report_count
);

  logic            take;
  logic            desc_valid;
  hars_pkg::desc_t desc;

  hars_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_first   (in_first),
    .take       (take),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  hars_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .desc_valid   (desc_valid),
    .desc         (desc),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_source   (out_source),
    .report_count (out_report_count)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for hci_adv_report_splitter_core: H4 byte stream in, event bytes out.
// Predicts the split advertising reports and vendor passthrough bytes, then checks each one.
// Depends on rtl/hars_pkg.sv and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] H4_ACL           = 8'h02;
  localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
  localparam logic [7:0] EVT_CMD_STATUS   = 8'h0F;
  localparam logic [7:0] SUB_EXT_ADV_RPT  = 8'h0D;
  localparam int         STALL_LIMIT      = 2000;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        src;
    logic [31:0] count;
  } evt_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_source;
  logic [31:0] out_report_count;

  evt_byte_t   frames_due[$];
  int          mismatches = 0;
  int          useful_items = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  // parser state of the prediction
  hars_pkg::phase_t phase = hars_pkg::PH_IDLE;
  logic [7:0]  evt_left = 8'd0;
  logic [7:0]  rpt_left = 8'd0;
  logic [7:0]  pay_left = 8'd0;
  logic [7:0]  hold [hars_pkg::HDR_BYTES];
  int          hidx = 0;
  logic [31:0] emitted = 32'd0;

  hci_adv_report_splitter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_first         (in_first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_source       (out_source),
    .out_report_count (out_report_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void emit(logic [7:0] b, logic last, logic src);
    evt_byte_t e;
    e.data  = b;
    e.last  = last;
    e.src   = src;
    e.count = emitted;
    frames_due.push_back(e);
  endfunction

  task automatic parse_h4_byte(input logic [7:0] b, input logic first);
    if (first) begin
      phase = (b == hars_pkg::H4_EVENT) ? hars_pkg::PH_CODE : hars_pkg::PH_IDLE;
      return;
    end
    case (phase)
      hars_pkg::PH_CODE: begin
        if (b == hars_pkg::EVT_VENDOR) begin
          emit(b, 1'b0, hars_pkg::SRC_VENDOR);
          phase = hars_pkg::PH_VLEN;
        end else if (b == hars_pkg::EVT_LE_META) begin
          phase = hars_pkg::PH_MLEN;
        end else begin
          phase = hars_pkg::PH_IDLE;
        end
      end
      hars_pkg::PH_VLEN: begin
        emit(b, b == 8'd0, hars_pkg::SRC_VENDOR);
        evt_left = b;
        phase = (b == 8'd0) ? hars_pkg::PH_IDLE : hars_pkg::PH_VPASS;
      end
      hars_pkg::PH_VPASS: begin
        evt_left = evt_left - 8'd1;
        emit(b, evt_left == 8'd0, hars_pkg::SRC_VENDOR);
        if (evt_left == 8'd0) phase = hars_pkg::PH_IDLE;
      end
      hars_pkg::PH_MLEN: begin
        evt_left = b;
        phase = (b == 8'd0) ? hars_pkg::PH_IDLE : hars_pkg::PH_SUB;
      end
      hars_pkg::PH_SUB: begin
        evt_left = evt_left - 8'd1;
        phase = (b == hars_pkg::SUB_ADV_RPT && evt_left != 8'd0) ?
                hars_pkg::PH_NUM : hars_pkg::PH_IDLE;
      end
      hars_pkg::PH_NUM: begin
        evt_left = evt_left - 8'd1;
        rpt_left = b;
        hidx = 0;
        phase = (b != 8'd0 && evt_left != 8'd0) ? hars_pkg::PH_HDR : hars_pkg::PH_IDLE;
      end
      hars_pkg::PH_HDR: begin
        if (hidx < hars_pkg::HDR_BYTES) hold[hidx] = b;
        hidx++;
        evt_left = evt_left - 8'd1;
        if (hidx >= hars_pkg::HDR_BYTES) begin
          if (int'(evt_left) >= int'(b) + 1) begin
            emit(hars_pkg::EVT_LE_META, 1'b0, hars_pkg::SRC_ADV);
            emit(hars_pkg::FRAME_EXTRA + b, 1'b0, hars_pkg::SRC_ADV);
            emit(hars_pkg::SUB_ADV_RPT, 1'b0, hars_pkg::SRC_ADV);
            emit(hars_pkg::ONE_REPORT, 1'b0, hars_pkg::SRC_ADV);
            for (int i = 0; i < hars_pkg::HDR_BYTES; i++)
              emit(hold[i], 1'b0, hars_pkg::SRC_ADV);
            pay_left = b;
            phase = (b == 8'd0) ? hars_pkg::PH_RSSI : hars_pkg::PH_DATA;
          end else begin
            phase = hars_pkg::PH_IDLE;
          end
        end else if (evt_left == 8'd0) begin
          phase = hars_pkg::PH_IDLE;
        end
      end
      hars_pkg::PH_DATA: begin
        emit(b, 1'b0, hars_pkg::SRC_ADV);
        evt_left = evt_left - 8'd1;
        pay_left = pay_left - 8'd1;
        if (pay_left == 8'd0) phase = hars_pkg::PH_RSSI;
      end
      hars_pkg::PH_RSSI: begin
        emit(b, 1'b1, hars_pkg::SRC_ADV);
        evt_left = evt_left - 8'd1;
        emitted = emitted + 32'd1;
        rpt_left = rpt_left - 8'd1;
        hidx = 0;
        phase = (rpt_left != 8'd0 && evt_left != 8'd0) ?
                hars_pkg::PH_HDR : hars_pkg::PH_IDLE;
      end
      default: phase = hars_pkg::PH_IDLE;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_first <= first;
    do @(posedge clk); while (!in_ready);
    parse_h4_byte(b, first);
  endtask

  task automatic send_packet(input logic [7:0] pkt[$], input int n, input bit counts);
    for (int k = 0; k < n; k++) push_byte(pkt[k], k == 0);
    if (counts) useful_items += n;
  endtask

  task automatic send_adv_event();
    logic [7:0] params[$];
    logic [7:0] pkt[$];
    int nrep, dl_real, dl_field, plen, mode, n;
    nrep = $urandom_range(1, 3);
    params.push_back(hars_pkg::SUB_ADV_RPT);
    params.push_back(8'(nrep));
    for (int r = 0; r < nrep; r++) begin
      dl_real = $urandom_range(0, 6);
      dl_field = ($urandom_range(0, 9) == 0) ? $urandom_range(dl_real + 1, 255) : dl_real;
      repeat (8) params.push_back(8'($urandom));
      params.push_back(8'(dl_field));
      repeat (dl_real) params.push_back(8'($urandom));
      params.push_back(8'($urandom));
    end
    plen = params.size();
    mode = $urandom_range(0, 9);
    if (mode == 0) plen = plen - $urandom_range(1, 12);
    else if (mode == 1) params[1] = 8'(nrep + $urandom_range(1, 3));
    else if (mode == 2) repeat ($urandom_range(1, 4)) params.push_back(8'($urandom));
    pkt.push_back(hars_pkg::H4_EVENT);
    pkt.push_back(hars_pkg::EVT_LE_META);
    pkt.push_back(8'(plen));
    foreach (params[k]) pkt.push_back(params[k]);
    n = pkt.size();
    if (mode == 3) n = $urandom_range(1, n - 1);
    send_packet(pkt, n, 1'b1);
  endtask

  task automatic send_vendor_event();
    logic [7:0] pkt[$];
    int vlen, n;
    vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    pkt.push_back(hars_pkg::H4_EVENT);
    pkt.push_back(hars_pkg::EVT_VENDOR);
    pkt.push_back(8'(vlen));
    repeat ((vlen > 12) ? 12 : vlen) pkt.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    n = pkt.size();
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
    send_packet(pkt, n, 1'b1);
  endtask

  task automatic send_ignored_packet();
    logic [7:0] pkt[$];
    case ($urandom_range(0, 6))
      0: pkt.push_back(H4_ACL);
      1: begin
        pkt.push_back(hars_pkg::H4_EVENT);
        pkt.push_back(EVT_CMD_COMPLETE);
        pkt.push_back(8'($urandom_range(1, 8)));
      end
      2: begin
        pkt.push_back(hars_pkg::H4_EVENT);
        pkt.push_back(EVT_CMD_STATUS);
        pkt.push_back(8'd4);
      end
      3: begin
        pkt.push_back(hars_pkg::H4_EVENT);
        pkt.push_back(hars_pkg::EVT_LE_META);
        pkt.push_back(8'($urandom_range(1, 20)));
        pkt.push_back(SUB_EXT_ADV_RPT);
      end
      4: begin
        pkt.push_back(hars_pkg::H4_EVENT);
        pkt.push_back(hars_pkg::EVT_LE_META);
        pkt.push_back(8'($urandom_range(1, 20)));
        pkt.push_back(hars_pkg::SUB_ADV_RPT);
        pkt.push_back(8'd0);
      end
      5: begin
        pkt.push_back(hars_pkg::H4_EVENT);
        pkt.push_back(hars_pkg::EVT_LE_META);
        pkt.push_back(8'd0);
      end
      default: pkt.push_back(8'($urandom));
    endcase
    repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
    send_packet(pkt, pkt.size(), 1'b0);
  endtask

  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) send_adv_event();
    else if (pick < 7) send_vendor_event();
    else send_ignored_packet();
  endtask

  task automatic test_unframed_bytes();
    push_byte(hars_pkg::EVT_VENDOR, 1'b0);
    push_byte(hars_pkg::H4_EVENT, 1'b0);
  endtask

  task automatic test_vendor_empty();
    push_byte(hars_pkg::H4_EVENT, 1'b1);
    push_byte(hars_pkg::EVT_VENDOR, 1'b0);
    push_byte(8'h00, 1'b0);
  endtask

  task automatic test_meta_empty();
    push_byte(hars_pkg::H4_EVENT, 1'b1);
    push_byte(hars_pkg::EVT_LE_META, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(hars_pkg::SUB_ADV_RPT, 1'b0);
  endtask

  task automatic test_single_report();
    logic [7:0] pkt[$];
    pkt.push_back(hars_pkg::H4_EVENT);
    pkt.push_back(hars_pkg::EVT_LE_META);
    pkt.push_back(8'd12);
    pkt.push_back(hars_pkg::SUB_ADV_RPT);
    pkt.push_back(8'd1);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    repeat (6) pkt.push_back(8'($urandom));
    pkt.push_back(8'd0);
    pkt.push_back(8'h80);
    send_packet(pkt, pkt.size(), 1'b1);
  endtask

  task automatic test_random_events();
    while (useful_items < 90) send_random_packet();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    while (useful_items < 130) send_random_packet();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches < 50)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    evt_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches < 50)
          $display("%0t: unexpected item, expected none, got byte %0h", $time, out_byte);
      end else begin
        want = frames_due.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_last", want.last, out_last);
        check_field("out_source", want.src, out_source);
        check_field("out_report_count", want.count, out_report_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unframed_bytes();
    test_vendor_empty();
    test_meta_empty();
    test_single_report();
    test_random_events();
    test_back_to_back();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### hci_adv_report_splitter_core.f
rtl/hars_pkg.sv
rtl/hars_parser.sv
rtl/hars_out.sv
rtl/hci_adv_report_splitter_core.sv
verif/testbench.sv
